### src/bfr_pkg.sv
// Shared constants, codes and types for the buffer frame replacement block.
package bfr_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int PIN_BITS   = 8;

    localparam int IDX_W  = $clog2(NUM_FRAMES);
    localparam int FILL_W = $clog2(NUM_FRAMES + 1);

    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int FIDX_OUT_W  = 4;
    localparam int PAGE_OUT_W  = 16;
    localparam int PIN_OUT_W   = 8;
    localparam int CNT_W       = 32;
    localparam int CFG_FRAMES_W = 5;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int OUT_BITS    = STATUS_W + FIDX_OUT_W + 2 + PAGE_OUT_W + PIN_OUT_W + 2 * CNT_W;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_PIN   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UNPIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DIRTY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_RES  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_PIN = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY        = 8'd1;

    localparam logic [1:0] FS_INC   = 2'd0;
    localparam logic [1:0] FS_DEC   = 2'd1;
    localparam logic [1:0] FS_DIRTY = 2'd2;
    localparam logic [1:0] FS_LOAD  = 2'd3;

    typedef struct packed {
        logic                 en;
        logic [1:0]           op;
        logic [IDX_W-1:0]     idx;
        logic [PAGE_BITS-1:0] tag;
    } fs_cmd_t;

    typedef struct packed {
        logic                 valid;
        logic                 dirty;
        logic [PIN_BITS-1:0]  pins;
        logic [PAGE_BITS-1:0] tag;
    } fs_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] pos;
    } ol_cmd_t;

endpackage

### src/bfr_frame_store.sv
// Per-frame tag, valid, dirty and pin count storage with one read port.
module bfr_frame_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bfr_pkg::IDX_W-1:0]  rd_idx,
    output bfr_pkg::fs_rd_t            rd,
    input  bfr_pkg::fs_cmd_t           cmd
);
    import bfr_pkg::*;

    logic [PAGE_BITS-1:0] tag_reg   [NUM_FRAMES];
    logic                 valid_reg [NUM_FRAMES];
    logic                 valid_next[NUM_FRAMES];
    logic                 dirty_reg [NUM_FRAMES];
    logic                 dirty_next[NUM_FRAMES];
    logic [PIN_BITS-1:0]  pins_reg  [NUM_FRAMES];
    logic [PIN_BITS-1:0]  pins_next [NUM_FRAMES];

    assign rd.valid = valid_reg[rd_idx];
    assign rd.dirty = dirty_reg[rd_idx];
    assign rd.pins  = pins_reg[rd_idx];
    assign rd.tag   = tag_reg[rd_idx];

    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            valid_next[i] = valid_reg[i];
            dirty_next[i] = dirty_reg[i];
            pins_next[i]  = pins_reg[i];
        end
        if (cmd.en)
        begin
            case (cmd.op)
                FS_INC:
                begin
                    if (pins_reg[cmd.idx] != PIN_MAX)
                    begin
                        pins_next[cmd.idx] = pins_reg[cmd.idx] + 1'b1;
                    end
                end
                FS_DEC:
                begin
                    if (pins_reg[cmd.idx] != '0)
                    begin
                        pins_next[cmd.idx] = pins_reg[cmd.idx] - 1'b1;
                    end
                end
                FS_DIRTY:
                begin
                    dirty_next[cmd.idx] = 1'b1;
                end
                default:
                begin
                    valid_next[cmd.idx] = 1'b1;
                    dirty_next[cmd.idx] = 1'b0;
                    pins_next[cmd.idx]  = PIN_BITS'(1);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                dirty_reg[i] <= 1'b0;
                pins_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid_reg[i] <= valid_next[i];
                dirty_reg[i] <= dirty_next[i];
                pins_reg[i]  <= pins_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en && cmd.op == FS_LOAD)
        begin
            tag_reg[cmd.idx] <= cmd.tag;
        end
    end

endmodule

### src/bfr_order_list.sv
// Replacement order list with one read port and a move-to-front operation.
module bfr_order_list (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bfr_pkg::IDX_W-1:0]  rd_pos,
    output logic [bfr_pkg::IDX_W-1:0]  rd_frame,
    input  bfr_pkg::ol_cmd_t           cmd
);
    import bfr_pkg::*;

    logic [IDX_W-1:0] order_reg [NUM_FRAMES];
    logic [IDX_W-1:0] order_next[NUM_FRAMES];

    assign rd_frame = order_reg[rd_pos];

    always_comb
    begin
        for (int p = 0; p < NUM_FRAMES; p++)
        begin
            order_next[p] = order_reg[p];
        end
        if (cmd.en)
        begin
            order_next[0] = order_reg[cmd.pos];
            for (int p = 1; p < NUM_FRAMES; p++)
            begin
                if (IDX_W'(p) <= cmd.pos)
                begin
                    order_next[p] = order_reg[p-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_FRAMES; p++)
            begin
                order_reg[p] <= IDX_W'(p);
            end
        end
        else
        begin
            for (int p = 0; p < NUM_FRAMES; p++)
            begin
                order_reg[p] <= order_next[p];
            end
        end
    end

endmodule

### src/buffer_frame_replacement_top.sv
// Top level: request sequencer, counters and stream ports of the frame manager.
// A request is accepted only while the sequencer is idle; the tag scan visits every frame in turn.
// Hits and refusals go from the decide state to the output state, which registers the result beat;
// loads pass the load and move states; LRU hits first search the order list for the hit frame,
// full-pool misses for an unpinned victim. Output holds while an older beat waits on m_tready.
// Reset is asynchronous: all frames become empty, order list identity, counters zero.
module buffer_frame_replacement_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // page_num
    input  logic [1:0]                       s_tuser,  // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status, frame_index, need_writeback, evict_valid, evicted_page, pin_count,
    // reads_done, writes_done, zero fill
    output logic [bfr_pkg::OUT_W-1:0]        m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bfr_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_FINDPOS = 3'd3;
    localparam logic [2:0] S_VICTIM  = 3'd4;
    localparam logic [2:0] S_LOAD    = 3'd5;
    localparam logic [2:0] S_MOVE    = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

    logic [2:0]              state_reg, state_next;
    logic [REQ_W-1:0]        req_reg, req_next;
    logic [PAGE_BITS-1:0]    page_reg, page_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        hit_frame_reg, hit_frame_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [IDX_W-1:0]        frame_reg, frame_next;
    logic [PIN_BITS-1:0]     pins_reg, pins_next;
    logic                    wb_reg, wb_next;
    logic                    ev_reg, ev_next;
    logic [PAGE_BITS-1:0]    evpage_reg, evpage_next;
    logic [FILL_W-1:0]       filled_reg, filled_next;
    logic [CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]        wr_cnt_reg, wr_cnt_next;
    logic [CFG_FRAMES_W-1:0] cfg_frames_reg;
    logic                    cfg_policy_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]        m_tdata_reg, m_tdata_next;

    logic [FILL_W-1:0]       limit;
    logic [IDX_W-1:0]        fs_rd_idx;
    fs_rd_t                  fs_rd;
    fs_cmd_t                 fs_cmd;
    logic [IDX_W-1:0]        ol_rd_pos;
    logic [IDX_W-1:0]        ol_rd_frame;
    ol_cmd_t                 ol_cmd;
    logic                    in_fire;

    bfr_frame_store u_frames (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (fs_rd_idx),
        .rd     (fs_rd),
        .cmd    (fs_cmd)
    );

    bfr_order_list u_order (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_pos   (ol_rd_pos),
        .rd_frame (ol_rd_frame),
        .cmd      (ol_cmd)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        if (cfg_frames_reg == '0)
        begin
            limit = FILL_W'(1);
        end
        else if (32'(cfg_frames_reg) > NUM_FRAMES)
        begin
            limit = FILL_W'(NUM_FRAMES);
        end
        else
        begin
            limit = FILL_W'(cfg_frames_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        page_next      = page_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        hit_frame_next = hit_frame_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        frame_next     = frame_reg;
        pins_next      = pins_reg;
        wb_next        = wb_reg;
        ev_next        = ev_reg;
        evpage_next    = evpage_reg;
        filled_next    = filled_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_cnt_next    = wr_cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        fs_rd_idx      = cnt_reg;
        ol_rd_pos      = cnt_reg;
        fs_cmd         = '{en: 1'b0, op: FS_INC, idx: hit_frame_reg, tag: page_reg};
        ol_cmd         = '{en: 1'b0, pos: pos_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_next    = s_tuser;
                    page_next   = PAGE_BITS'(s_tdata);
                    cnt_next    = '0;
                    hit_next    = 1'b0;
                    wb_next     = 1'b0;
                    ev_next     = 1'b0;
                    evpage_next = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!hit_reg && fs_rd.valid && fs_rd.tag == page_reg)
                begin
                    hit_next       = 1'b1;
                    hit_frame_next = cnt_reg;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                fs_rd_idx   = hit_frame_reg;
                frame_next  = hit_frame_reg;
                status_next = ST_HIT;
                state_next  = S_OUT;
                case (req_reg)
                    REQ_PIN:
                    begin
                        if (hit_reg)
                        begin
                            fs_cmd.en = 1'b1;
                            fs_cmd.op = FS_INC;
                            pins_next = (fs_rd.pins == PIN_MAX) ? PIN_MAX
                                                                : fs_rd.pins + 1'b1;
                            if (cfg_policy_reg)
                            begin
                                cnt_next   = '0;
                                state_next = S_FINDPOS;
                            end
                        end
                        else if (filled_reg < limit)
                        begin
                            pos_next    = IDX_W'(filled_reg);
                            filled_next = filled_reg + 1'b1;
                            state_next  = S_LOAD;
                        end
                        else
                        begin
                            cnt_next   = IDX_W'(filled_reg - FILL_W'(1));
                            state_next = S_VICTIM;
                        end
                    end
                    REQ_UNPIN:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_RES;
                            frame_next  = '0;
                            pins_next   = '0;
                        end
                        else if (fs_rd.pins != '0)
                        begin
                            fs_cmd.en = 1'b1;
                            fs_cmd.op = FS_DEC;
                            pins_next = fs_rd.pins - 1'b1;
                        end
                        else
                        begin
                            status_next = ST_ZERO_PIN;
                            pins_next   = '0;
                        end
                    end
                    REQ_DIRTY:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = ST_NOT_RES;
                            frame_next  = '0;
                            pins_next   = '0;
                        end
                        else
                        begin
                            fs_cmd.en = 1'b1;
                            fs_cmd.op = FS_DIRTY;
                            pins_next = fs_rd.pins;
                        end
                    end
                    default:
                    begin
                        status_next = ST_NOT_RES;
                        frame_next  = '0;
                        pins_next   = '0;
                    end
                endcase
            end
            S_FINDPOS:
            begin
                if (ol_rd_frame == hit_frame_reg || cnt_reg == LAST_IDX)
                begin
                    pos_next   = cnt_reg;
                    state_next = S_MOVE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_VICTIM:
            begin
                fs_rd_idx = ol_rd_frame;
                if (fs_rd.pins == '0)
                begin
                    pos_next   = cnt_reg;
                    state_next = S_LOAD;
                end
                else if (cnt_reg == '0)
                begin
                    status_next = ST_NO_FRAME;
                    frame_next  = '0;
                    pins_next   = '0;
                    state_next  = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_LOAD:
            begin
                ol_rd_pos = pos_reg;
                fs_rd_idx = ol_rd_frame;
                if (fs_rd.valid)
                begin
                    ev_next     = 1'b1;
                    evpage_next = fs_rd.tag;
                    if (fs_rd.dirty)
                    begin
                        wb_next     = 1'b1;
                        wr_cnt_next = wr_cnt_reg + 1'b1;
                    end
                end
                rd_cnt_next = rd_cnt_reg + 1'b1;
                fs_cmd      = '{en: 1'b1, op: FS_LOAD, idx: ol_rd_frame, tag: page_reg};
                status_next = ST_LOADED;
                frame_next  = ol_rd_frame;
                pins_next   = PIN_BITS'(1);
                state_next  = S_MOVE;
            end
            S_MOVE:
            begin
                ol_cmd.en  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(OUT_W - OUT_BITS)'(0), wr_cnt_reg, rd_cnt_reg,
                                     PIN_OUT_W'(pins_reg), PAGE_OUT_W'(evpage_reg),
                                     ev_reg, wb_reg, FIDX_OUT_W'(frame_reg), status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            filled_reg     <= '0;
            rd_cnt_reg     <= '0;
            wr_cnt_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            cfg_frames_reg <= CFG_FRAMES_W'(NUM_FRAMES);
            cfg_policy_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            filled_reg   <= filled_next;
            rd_cnt_reg   <= rd_cnt_next;
            wr_cnt_reg   <= wr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FRAMES_IN_USE)
                begin
                    cfg_frames_reg <= cfg_data[CFG_FRAMES_W-1:0];
                end
                else if (cfg_index == CFG_POLICY)
                begin
                    cfg_policy_reg <= cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        page_reg      <= page_next;
        cnt_reg       <= cnt_next;
        hit_reg       <= hit_next;
        hit_frame_reg <= hit_frame_next;
        pos_reg       <= pos_next;
        status_reg    <= status_next;
        frame_reg     <= frame_next;
        pins_reg      <= pins_next;
        wb_reg        <= wb_next;
        ev_reg        <= ev_next;
        evpage_reg    <= evpage_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // An accepted beat always starts the tag scan.
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_SCAN)
        else $error("accepted beat did not start the tag scan");

    // The fill count never passes the built number of frames.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_W'(NUM_FRAMES))
        else $error("fill count exceeds frame count");

    // A new result beat appears only from the output state.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result beat raised outside the output state");

    // A load always bumps the read counter by one.
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |=> rd_cnt_reg == $past(rd_cnt_reg) + 1'b1)
        else $error("page load did not advance the read counter");

endmodule
